[hw/rtl/b2nv12_pkg.sv]
// Shared types and constants for the BGR to NV12 converter.
// Depends on nothing; every other file in hw/rtl imports it.
`timescale 1ns / 1ps

package b2nv12_pkg;

    // Frame size limits and derived widths.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SIZE_W     = 13;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 12;
    localparam int SLOT_W     = $clog2(LINE_DEPTH);

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1920);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);
    localparam logic [SIZE_W-1:0] WIDTH_TOP    = SIZE_W'(MAX_WIDTH - (MAX_WIDTH % 2));
    localparam logic [SIZE_W-1:0] HEIGHT_TOP   = SIZE_W'(MAX_HEIGHT - (MAX_HEIGHT % 2));

    // BT.601 studio-range coefficients.
    localparam logic [15:0] Y_R = 16'd66;
    localparam logic [15:0] Y_G = 16'd129;
    localparam logic [15:0] Y_B = 16'd25;
    localparam logic [15:0] Y_ROUND = 16'd128;
    localparam logic [7:0]  Y_OFFSET = 8'd16;

    localparam logic signed [16:0] U_R = -17'sd38;
    localparam logic signed [16:0] U_G = -17'sd74;
    localparam logic signed [16:0] U_B = 17'sd112;
    localparam logic signed [16:0] V_R = 17'sd112;
    localparam logic signed [16:0] V_G = -17'sd94;
    localparam logic signed [16:0] V_B = -17'sd18;
    localparam logic signed [16:0] C_ROUND = 17'sd128;
    localparam logic [7:0]  C_OFFSET = 8'd128;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       frame_end;
    } t_result;

    // Horizontal pair sums, one 9-bit sum per channel.
    typedef struct packed {
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
    } t_pair_sum;

    // Position of the pixel currently at the input.
    typedef struct packed {
        logic              odd_col;
        logic              odd_row;
        logic [SLOT_W-1:0] slot;
        logic              frame_last;
    } t_pos_info;

    // Control and pixel carried alongside the line store read.
    typedef struct packed {
        t_pixel pixel;
        logic   chroma;
        logic   frame_last;
    } t_stage1;

endpackage

[hw/rtl/b2nv12_pos.sv]
// Size registers and raster position counters of the converter.
// Depends on b2nv12_pkg.
`timescale 1ns / 1ps

module b2nv12_pos (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  b2nv12_pkg::t_cfg_index       i_cfg_index,
    input  logic [b2nv12_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                         i_accept,
    output b2nv12_pkg::t_pos_info        o_pos
);
    import b2nv12_pkg::*;

    logic [SIZE_W-1:0] r_frame_width;
    logic [SIZE_W-1:0] r_frame_height;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic              row_last;
    logic              frame_last;

    // Bit 0 cleared, then clamped to the range 2 .. top.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v_reg,
                                                   input logic [SIZE_W-1:0] v_top);
        logic [SIZE_W-1:0] v;
        v = {v_reg[SIZE_W-1:1], 1'b0};
        if (v < SIZE_W'(2)) v = SIZE_W'(2);
        if (v > v_top) v = v_top;
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff      = eff_size(r_frame_width, WIDTH_TOP);
        h_eff      = eff_size(r_frame_height, HEIGHT_TOP);
        row_last   = {1'b0, r_col} >= (w_eff - SIZE_W'(1));
        frame_last = row_last && ({1'b0, r_row} >= (h_eff - SIZE_W'(1)));
        if (row_last) begin
            n_col = '0;
            n_row = frame_last ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.odd_col    = r_col[0];
    assign o_pos.odd_row    = r_row[0];
    assign o_pos.slot       = r_col[SLOT_W:1];
    assign o_pos.frame_last = frame_last;

endmodule

[hw/rtl/b2nv12_line.sv]
// Left pixel register and the line store of horizontal pair sums.
// Depends on b2nv12_pkg.
`timescale 1ns / 1ps

module b2nv12_line (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  b2nv12_pkg::t_pixel    i_pixel,
    input  b2nv12_pkg::t_pos_info i_pos,
    output b2nv12_pkg::t_pair_sum o_cur_sum,
    output b2nv12_pkg::t_pair_sum o_top_sum
);
    import b2nv12_pkg::*;

    t_pair_sum r_line_mem [LINE_DEPTH];
    t_pair_sum r_top_sum;
    t_pair_sum r_cur_sum;
    t_pair_sum n_cur_sum;
    t_pixel    r_left;
    logic      wr_en;
    logic      rd_en;

    always_comb begin
        n_cur_sum.blue  = {1'b0, r_left.blue}  + {1'b0, i_pixel.blue};
        n_cur_sum.green = {1'b0, r_left.green} + {1'b0, i_pixel.green};
        n_cur_sum.red   = {1'b0, r_left.red}   + {1'b0, i_pixel.red};
    end

    // Even rows write the slot and odd rows read it a full row later, so a read
    // never meets a write to the same slot in flight.
    assign wr_en = i_accept && i_pos.odd_col && !i_pos.odd_row;
    assign rd_en = i_accept && i_pos.odd_col && i_pos.odd_row;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_mem[i_pos.slot] <= n_cur_sum;
        end
        if (rd_en) begin
            r_top_sum <= r_line_mem[i_pos.slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cur_sum <= n_cur_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_accept) begin
            r_left <= i_pixel;
        end
    end

    assign o_cur_sum = r_cur_sum;
    assign o_top_sum = r_top_sum;

endmodule

[hw/rtl/b2nv12_color.sv]
// Colour conversion stages: luma and 2x2 averages, then chroma and output register.
// Depends on b2nv12_pkg.
`timescale 1ns / 1ps

module b2nv12_color (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s1_valid,
    input  b2nv12_pkg::t_stage1   i_s1,
    input  b2nv12_pkg::t_pair_sum i_cur_sum,
    input  b2nv12_pkg::t_pair_sum i_top_sum,
    output logic                  o_s1_take,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output b2nv12_pkg::t_result   o_result
);
    import b2nv12_pkg::*;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma;
        logic [7:0] avg_b;
        logic [7:0] avg_g;
        logic [7:0] avg_r;
        logic       frame_end;
    } t_stage2;

    t_stage2 r_s2, n_s2;
    t_result r_result, n_result;
    logic    r_v2;
    logic    r_v3;
    logic    s2_en;
    logic    s3_en;

    logic [15:0]        y_sum;
    logic [9:0]         sum_b, sum_g, sum_r;
    logic signed [16:0] ab_s, ag_s, ar_s;
    logic signed [16:0] u_t, v_t;

    assign s3_en     = !r_v3 || i_out_ready;
    assign s2_en     = !r_v2 || s3_en;
    assign o_s1_take = s2_en;

    always_comb begin
        y_sum = Y_R * {8'd0, i_s1.pixel.red} + Y_G * {8'd0, i_s1.pixel.green}
              + Y_B * {8'd0, i_s1.pixel.blue} + Y_ROUND;
        sum_b = {1'b0, i_cur_sum.blue}  + {1'b0, i_top_sum.blue};
        sum_g = {1'b0, i_cur_sum.green} + {1'b0, i_top_sum.green};
        sum_r = {1'b0, i_cur_sum.red}   + {1'b0, i_top_sum.red};
        n_s2.luma      = y_sum[15:8] + Y_OFFSET;
        n_s2.chroma    = i_s1.chroma;
        n_s2.avg_b     = sum_b[9:2];
        n_s2.avg_g     = sum_g[9:2];
        n_s2.avg_r     = sum_r[9:2];
        n_s2.frame_end = i_s1.frame_last;
    end

    // The floor shift by eight keeps bits 15:8 of the two's complement sum.
    always_comb begin
        ab_s = $signed({9'd0, r_s2.avg_b});
        ag_s = $signed({9'd0, r_s2.avg_g});
        ar_s = $signed({9'd0, r_s2.avg_r});
        u_t  = U_R * ar_s + U_G * ag_s + U_B * ab_s + C_ROUND;
        v_t  = V_R * ar_s + V_G * ag_s + V_B * ab_s + C_ROUND;
        n_result.luma         = r_s2.luma;
        n_result.chroma_valid = r_s2.chroma;
        n_result.chroma_u     = r_s2.chroma ? u_t[15:8] + C_OFFSET : 8'd0;
        n_result.chroma_v     = r_s2.chroma ? v_t[15:8] + C_OFFSET : 8'd0;
        n_result.frame_end    = r_s2.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s2_en) r_v2 <= i_s1_valid;
            if (s3_en) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) r_s2 <= n_s2;
        if (s3_en) r_result <= n_result;
    end

    assign o_out_valid = r_v3;
    assign o_result    = r_result;

endmodule

[hw/rtl/bgra_to_nv12_converter.sv]
// Streaming BGR to NV12 (BT.601 studio range) converter, top level.
// Throughput: one pixel per cycle while i_out_ready stays high, through three stages.
// Reset (synchronous, active low) clears counters, left pixel and pipeline valids;
// size registers return to 1920 x 1080. The line store is not cleared.
`timescale 1ns / 1ps

module bgra_to_nv12_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  b2nv12_pkg::t_cfg_index        i_cfg_index,
    input  logic [b2nv12_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  b2nv12_pkg::t_pixel            i_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output b2nv12_pkg::t_result           o_result
);
    import b2nv12_pkg::*;

    // Stage 1 holds the accepted pixel while the line store read for it
    // completes. Stage 2 computes luma and the 2x2 averages, and stage 3 is
    // the output register with the chroma result. Every stage moves whenever
    // the one after it is empty or moving, so a new input beat can be taken while
    // a finished result still waits for the consumer.

    t_pos_info pos;
    t_pair_sum cur_sum;
    t_pair_sum top_sum;
    t_stage1   r_s1, n_s1;
    logic      r_v1;
    logic      s1_take;
    logic      accept;

    assign o_in_ready = !r_v1 || s1_take;
    assign accept     = i_in_valid && o_in_ready;

    // Position counters and the size registers.
    b2nv12_pos u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .o_pos       (pos)
    );

    // Even rows store pair sums; odd rows read them back on their odd columns.
    b2nv12_line u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_pixel   (i_pixel),
        .i_pos     (pos),
        .o_cur_sum (cur_sum),
        .o_top_sum (top_sum)
    );

    always_comb begin
        n_s1.pixel      = i_pixel;
        n_s1.chroma     = pos.odd_col && pos.odd_row;
        n_s1.frame_last = pos.frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_in_ready) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    b2nv12_color u_color (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (r_v1),
        .i_s1        (r_s1),
        .i_cur_sum   (cur_sum),
        .i_top_sum   (top_sum),
        .o_s1_take   (s1_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

`ifndef SYNTHESIS
    // The last pixel of a frame sends the position back to the first pixel.
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && pos.frame_last |=> pos.slot == '0 && !pos.odd_col && !pos.odd_row)
        else $error("position did not wrap after the last pixel of the frame");

    // A stalled stage 1 keeps its beat, since the line store read is not repeated.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !s1_take |=> r_v1 && $stable(r_s1))
        else $error("stage 1 lost or changed a stalled beat");

    // Input back-pressure only arises with stage 1 occupied.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_v1 && !s1_take)
        else $error("input stalled with room in stage 1");
`endif

endmodule

[bench/bgra_to_nv12_converter_tb.sv]
// Self-checking testbench for the streaming BGR to NV12 converter.
// Depends on b2nv12_pkg and bgra_to_nv12_converter; predicts luma, chroma and frame end per pixel.
`timescale 1ns / 1ps

module bgra_to_nv12_converter_tb;

    import b2nv12_pkg::*;

    // Run control. Spare cycles after the scoreboard empties let the block drain
    // before a size write or the final verdict.
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int RANDOM_ITEMS = 1200;

    // Block ports. Every input has a known value from time zero.
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    t_cfg_index          i_cfg_index = REG_FRAME_WIDTH;
    logic [SIZE_W-1:0]   i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_pixel              i_pixel     = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_result             o_result;

    // Stimulus and scoreboard storage.
    t_pixel              pixel_queue[$];
    t_result             expected_results[$];
    t_result             oldest_result;
    logic                pixel_taken = 1'b0;
    bit                  calm        = 1'b0;
    int                  fail_count  = 0;
    int unsigned         cycle_count = 0;

    // Our own copy of the converter state: size registers, raster position, the
    // previous pixel and the line of horizontal pair sums from the last even row.
    logic [SIZE_W-1:0]   width_reg   = WIDTH_RESET;
    logic [SIZE_W-1:0]   height_reg  = HEIGHT_RESET;
    logic [COL_W-1:0]    col_pos     = '0;
    logic [ROW_W-1:0]    row_pos     = '0;
    t_pixel              left_px     = '0;
    t_pair_sum           pair_line [LINE_DEPTH];

    bgra_to_nv12_converter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The size the block really uses: bit 0 dropped, at least 2, at most the limit
    // rounded down to even.
    function automatic int usable_size(logic [SIZE_W-1:0] reg_val, int limit);
        int top;
        int v;
        top = limit & ~1;
        v   = int'(reg_val) & ~1;
        if (top < 2) top = 2;
        if (v < 2) v = 2;
        if (v > top) v = top;
        return v;
    endfunction

    // Works out the result beat for one accepted pixel and advances the state.
    // Luma comes from every pixel; chroma only on the odd column of an odd row,
    // where the 2x2 block is complete and each channel is averaged with a floor.
    function automatic t_result convert_pixel(t_pixel px);
        int                line_w;
        int                line_h;
        int                avg_b;
        int                avg_g;
        int                avg_r;
        int                sum_u;
        int                sum_v;
        logic [SLOT_W-1:0] slot;
        logic              row_last;
        logic              frame_last;
        t_pair_sum         pair;
        t_pair_sum         above;
        t_result           res;
        line_w     = usable_size(width_reg, MAX_WIDTH);
        line_h     = usable_size(height_reg, MAX_HEIGHT);
        slot       = col_pos[COL_W-1:1];
        row_last   = int'(col_pos) >= line_w - 1;
        frame_last = row_last && (int'(row_pos) >= line_h - 1);
        res        = '0;
        res.luma   = 8'(((66 * px.red + 129 * px.green + 25 * px.blue + 128) >> 8) + 16);
        if (col_pos[0]) begin
            pair.blue  = 9'(left_px.blue) + 9'(px.blue);
            pair.green = 9'(left_px.green) + 9'(px.green);
            pair.red   = 9'(left_px.red) + 9'(px.red);
            if (!row_pos[0]) begin
                pair_line[slot] = pair;
            end else begin
                above = pair_line[slot];
                avg_b = (int'(pair.blue) + int'(above.blue)) >> 2;
                avg_g = (int'(pair.green) + int'(above.green)) >> 2;
                avg_r = (int'(pair.red) + int'(above.red)) >> 2;
                // The shift must floor negative sums, hence the arithmetic shift.
                sum_u = -38 * avg_r - 74 * avg_g + 112 * avg_b + 128;
                sum_v = 112 * avg_r - 94 * avg_g - 18 * avg_b + 128;
                res.chroma_u     = 8'((sum_u >>> 8) + 128);
                res.chroma_v     = 8'((sum_v >>> 8) + 128);
                res.chroma_valid = 1'b1;
            end
        end
        left_px = px;
        if (row_last) begin
            col_pos = '0;
            row_pos = frame_last ? '0 : row_pos + ROW_W'(1);
        end else begin
            col_pos = col_pos + COL_W'(1);
        end
        res.frame_end = frame_last;
        return res;
    endfunction

    // A gap roughly 30 times in a hundred calls, except during the calm stretch.
    function automatic bit take_gap();
        return !calm && ($urandom_range(99) < 30);
    endfunction

    // Channels lean towards the extremes so that both ends of every field turn up often.
    function automatic logic [7:0] random_channel();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly modest sizes; now and then one below the minimum or beyond the line store.
    function automatic int random_extent(int common_top);
        case ($urandom_range(11))
            0: return $urandom_range(1);
            1: return $urandom_range(MAX_WIDTH + 1, 8191);
            default: return $urandom_range(2, common_top);
        endcase
    endfunction

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Writes both size registers, one per cycle, and mirrors them in the predictor.
    // Only called while the block has nothing in flight.
    task automatic set_size(int wv, int hv);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_FRAME_WIDTH;
        i_cfg_data  <= SIZE_W'(wv);
        @(posedge i_clk);
        width_reg = SIZE_W'(wv);
        @(negedge i_clk);
        i_cfg_index <= REG_FRAME_HEIGHT;
        i_cfg_data  <= SIZE_W'(hv);
        @(posedge i_clk);
        height_reg = SIZE_W'(hv);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A uniform 2x2 block when the frame is two pixels wide.
    task automatic push_solid(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        repeat (4) pixel_queue.push_back(t_pixel'{blue: b, green: g, red: r});
    endtask

    task automatic push_random(int count);
        repeat (count) begin
            pixel_queue.push_back(t_pixel'{blue: random_channel(), green: random_channel(),
                                           red: random_channel()});
        end
    endtask

    task automatic wait_drained();
        while (pixel_queue.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver: inputs change on the falling edge. A new pixel beat is offered once the
    // previous one has gone, so valid holds steady with its payload until accepted.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || pixel_taken) begin
            if (pixel_queue.size() != 0 && !take_gap()) begin
                i_pixel    <= pixel_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= !take_gap();
    end

    // Monitor: on the rising edge an accepted pixel beat feeds the predictor, and an
    // accepted result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        pixel_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_results.push_back(convert_pixel(i_pixel));
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no pixel outstanding: luma %0d", o_result.luma);
                fail_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                check_field("luma", oldest_result.luma, o_result.luma);
                check_field("chroma_valid", 8'(oldest_result.chroma_valid),
                            8'(o_result.chroma_valid));
                check_field("chroma_u", oldest_result.chroma_u, o_result.chroma_u);
                check_field("chroma_v", oldest_result.chroma_v, o_result.chroma_v);
                check_field("frame_end", 8'(oldest_result.frame_end),
                            8'(o_result.frame_end));
            end
        end
    end

    // Watchdog: far beyond the slowest correct run of roughly twelve hundred pixels.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus. Sizes only change while the block is drained. The line store is never
    // cleared, so a change mid-frame must not make an odd row read a slot that no even
    // row has written: a wider frame is only allowed when the next row is even.
    initial begin
        int phase;
        int sent;
        int count;
        int wv;
        int hv;
        int fw;
        int fh;
        bit oversize;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: 2x2 frames of black, white, pure blue and pure red, so that
        // luma and both chroma samples reach their extremes.
        set_size(2, 2);
        push_solid(8'd0, 8'd0, 8'd0);
        push_solid(8'd255, 8'd255, 8'd255);
        push_solid(8'd255, 8'd0, 8'd0);
        push_solid(8'd0, 8'd0, 8'd255);
        wait_drained();

        // Zero width and an odd height both fall back to a 2x2 frame.
        set_size(0, 3);
        push_random(4);
        wait_drained();

        // Widest register value, then a narrower width mid-row: the column is already
        // past the new last column, so the row ends on the next pixel and the odd row
        // reads the slot written just before.
        set_size(8191, 1);
        push_random(2);
        wait_drained();
        set_size(3, 1);
        push_random(3);
        wait_drained();

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase == 0) begin
                // A long stretch without any idling on either side.
                calm = 1'b1;
                set_size(16, 4);
                count = 3 * 16 * 4;
            end else if (phase == 1) begin
                // Part of a row at the widest size reaches at least slot 99, short of the line store's far end.
                calm = 1'b0;
                set_size(MAX_WIDTH, 2);
                count = $urandom_range(200, 400);
            end else if (phase == 2) begin
                // Tallest frame, left part-way through; a later phase ends it early.
                set_size(2, MAX_HEIGHT);
                count = $urandom_range(30, 60);
            end else begin
                wv = random_extent(24);
                hv = random_extent(6);
                if (row_pos[0] && usable_size(SIZE_W'(wv), MAX_WIDTH) >
                                  usable_size(width_reg, MAX_WIDTH))
                    wv = int'(width_reg);
                set_size(wv, hv);
                fw = usable_size(width_reg, MAX_WIDTH);
                fh = usable_size(height_reg, MAX_HEIGHT);
                oversize = fw * fh > 1000;
                if (oversize)
                    count = $urandom_range(1, 60);
                else if ($urandom_range(1))
                    count = fw * fh * $urandom_range(1, 2);
                else
                    count = $urandom_range(1, 2 * fw * fh);
            end
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            push_random(count);
            sent += count;
            wait_drained();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/b2nv12_pkg.sv
hw/rtl/b2nv12_pos.sv
hw/rtl/b2nv12_line.sv
hw/rtl/b2nv12_color.sv
hw/rtl/bgra_to_nv12_converter.sv
bench/bgra_to_nv12_converter_tb.sv
